// ===== rtl/twa_pkg.sv =====
// Shared types and constants of the tape record word assembler.
`timescale 1ns / 1ps

package twa_pkg;

   localparam int FuncWidth    = 2;
   localparam int AddrWidth    = 15;
   localparam int WordWidth    = 48;
   localparam int CountWidth   = 10;
   localparam int RemainWidth  = 11;
   localparam int CharWidth    = 6;
   localparam int PosWidth     = 3;
   localparam int StatusWidth  = 2;

   localparam logic [RemainWidth-1:0] DefaultWords = RemainWidth'(1024);

   localparam logic [7:0] TapeMarkChar = 8'h8f;

   localparam logic [FuncWidth-1:0] FUNC_START = 2'd0;
   localparam logic [FuncWidth-1:0] FUNC_BYTE  = 2'd1;
   localparam logic [FuncWidth-1:0] FUNC_EOT   = 2'd2;

   localparam logic KIND_STORE = 1'b0;
   localparam logic KIND_DONE  = 1'b1;

   localparam logic [StatusWidth-1:0] STATUS_RECORD_END = 2'd0;
   localparam logic [StatusWidth-1:0] STATUS_TAPE_MARK  = 2'd1;
   localparam logic [StatusWidth-1:0] STATUS_NOT_BEGIN  = 2'd2;
   localparam logic [StatusWidth-1:0] STATUS_END_TAPE   = 2'd3;

   localparam int QueueDepth = 4;
   localparam int QueueAw    = $clog2(QueueDepth);

   // One classified operation: an optional store followed by an optional done.
   typedef struct packed {
      logic                   store_valid;
      logic                   done_valid;
      logic [AddrWidth-1:0]   store_address;
      logic [WordWidth-1:0]   store_word;
      logic [AddrWidth-1:0]   done_address;
      logic [StatusWidth-1:0] status;
      logic [CountWidth-1:0]  words_left;
      logic [PosWidth-1:0]    chars_in_word;
   } op_type;

endpackage

// ===== rtl/tape_record_word_assembler.sv =====
// Top level of the tape record word assembler.
// Each result is registered in the queue and then in the back end output register.
// Throughput: one request beat per cycle while the queue is not full; a record end
// with a partial word flush gives two result beats, sent one after the other.
// A four-entry operation queue absorbs output stalls before request ready drops.
// Reset (synchronous, active high) closes any open read and empties the queue.
`timescale 1ns / 1ps

module tape_record_word_assembler (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [twa_pkg::FuncWidth-1:0]       req_func,
   input  logic [7:0]                          req_frame_byte,
   input  logic [twa_pkg::AddrWidth-1:0]       req_start_address,
   input  logic [twa_pkg::CountWidth-1:0]      req_word_count,
   input  logic                                req_use_count,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_kind,
   output logic [twa_pkg::AddrWidth-1:0]       rsp_mem_address,
   output logic [twa_pkg::WordWidth-1:0]       rsp_mem_word,
   output logic [twa_pkg::StatusWidth-1:0]     rsp_status,
   output logic [twa_pkg::CountWidth-1:0]      rsp_words_left,
   output logic [twa_pkg::PosWidth-1:0]        rsp_chars_in_word,
   output logic                                rsp_last
);

   logic            push;
   logic            pop;
   logic            queue_full;
   logic            head_valid;
   twa_pkg::op_type push_op;
   twa_pkg::op_type head_op;

   twa_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_frame_byte    (req_frame_byte),
      .req_start_address (req_start_address),
      .req_word_count    (req_word_count),
      .req_use_count     (req_use_count),
      .queue_full        (queue_full),
      .push              (push),
      .push_op           (push_op)
   );

   twa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_op    (push_op),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_op    (head_op)
   );

   twa_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_op           (head_op),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_mem_address   (rsp_mem_address),
      .rsp_mem_word      (rsp_mem_word),
      .rsp_status        (rsp_status),
      .rsp_words_left    (rsp_words_left),
      .rsp_chars_in_word (rsp_chars_in_word),
      .rsp_last          (rsp_last)
   );

endmodule

// ===== rtl/twa_front.sv =====
// Front end: accepts request beats, tracks the read and classifies each beat.
`timescale 1ns / 1ps

module twa_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [twa_pkg::FuncWidth-1:0]       req_func,
   input  logic [7:0]                          req_frame_byte,
   input  logic [twa_pkg::AddrWidth-1:0]       req_start_address,
   input  logic [twa_pkg::CountWidth-1:0]      req_word_count,
   input  logic                                req_use_count,
   input  logic                                queue_full,
   output logic                                push,
   output twa_pkg::op_type                     push_op
);

   logic                               busy_ff, busy_in;
   logic [twa_pkg::WordWidth-1:0]      word_accum_ff, word_accum_in;
   logic [twa_pkg::PosWidth-1:0]       char_position_ff, char_position_in;
   logic                               at_first_char_ff, at_first_char_in;
   logic                               prev_was_mark_ff, prev_was_mark_in;
   logic [twa_pkg::AddrWidth-1:0]      core_address_ff, core_address_in;
   logic [twa_pkg::RemainWidth-1:0]    words_remaining_ff, words_remaining_in;
   logic                               count_in_use_ff, count_in_use_in;

   logic                               accept;
   logic                               marker;
   logic [twa_pkg::CharWidth-1:0]      char_bits;
   logic [5:0]                         shift_amount;
   logic [twa_pkg::WordWidth-1:0]      packed_word;
   logic                               has_budget;
   logic [twa_pkg::AddrWidth-1:0]      address_inc;
   logic [twa_pkg::RemainWidth-1:0]    remaining_dec;
   logic [twa_pkg::RemainWidth-1:0]    remaining_after;
   twa_pkg::op_type                    op;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   assign marker        = req_frame_byte[7];
   assign char_bits     = req_frame_byte[twa_pkg::CharWidth-1:0];
   // first character lands in the top six bits
   assign shift_amount  = 6'd6 * {3'b000, ~char_position_ff};
   assign packed_word   = word_accum_ff | (48'(char_bits) << shift_amount);
   assign has_budget    = words_remaining_ff != '0;
   assign address_inc   = core_address_ff + 15'd1;
   assign remaining_dec = words_remaining_ff - 11'd1;

   always_comb begin
      busy_in            = busy_ff;
      word_accum_in      = word_accum_ff;
      char_position_in   = char_position_ff;
      at_first_char_in   = at_first_char_ff;
      prev_was_mark_in   = prev_was_mark_ff;
      core_address_in    = core_address_ff;
      words_remaining_in = words_remaining_ff;
      count_in_use_in    = count_in_use_ff;
      remaining_after    = words_remaining_ff;

      op.store_valid   = 1'b0;
      op.done_valid    = 1'b0;
      op.store_address = core_address_ff;
      op.store_word    = word_accum_ff;
      op.done_address  = core_address_ff;
      op.status        = twa_pkg::STATUS_RECORD_END;
      op.chars_in_word = char_position_ff;

      if (accept) begin
         if (req_func == twa_pkg::FUNC_START) begin
            busy_in            = 1'b1;
            word_accum_in      = '0;
            char_position_in   = '0;
            at_first_char_in   = 1'b1;
            prev_was_mark_in   = 1'b0;
            core_address_in    = req_start_address;
            count_in_use_in    = req_use_count;
            words_remaining_in = req_use_count ? {1'b0, req_word_count}
                                               : twa_pkg::DefaultWords;
         end else if (busy_ff && req_func == twa_pkg::FUNC_EOT) begin
            op.done_valid = 1'b1;
            op.status     = twa_pkg::STATUS_END_TAPE;
            busy_in       = 1'b0;
         end else if (busy_ff && req_func == twa_pkg::FUNC_BYTE) begin
            if (marker && prev_was_mark_ff) begin
               op.done_valid = 1'b1;
               op.status     = twa_pkg::STATUS_TAPE_MARK;
               busy_in       = 1'b0;
            end else if (marker && !at_first_char_ff) begin
               // record end: flush a partial word while budget lasts
               op.store_valid = has_budget && (char_position_ff != '0);
               op.done_valid  = 1'b1;
               op.status      = twa_pkg::STATUS_RECORD_END;
               if (op.store_valid) begin
                  op.done_address    = address_inc;
                  remaining_after    = remaining_dec;
                  core_address_in    = address_inc;
                  words_remaining_in = remaining_dec;
               end
               busy_in = 1'b0;
            end else if (!marker && at_first_char_ff) begin
               op.done_valid = 1'b1;
               op.status     = twa_pkg::STATUS_NOT_BEGIN;
               busy_in       = 1'b0;
            end else begin
               prev_was_mark_in = (req_frame_byte == twa_pkg::TapeMarkChar);
               at_first_char_in = 1'b0;
               if (char_position_ff == '1) begin
                  op.store_valid   = has_budget;
                  op.store_word    = packed_word;
                  word_accum_in    = '0;
                  char_position_in = '0;
                  if (has_budget) begin
                     core_address_in    = address_inc;
                     words_remaining_in = remaining_dec;
                  end
               end else begin
                  word_accum_in    = packed_word;
                  char_position_in = char_position_ff + 3'd1;
               end
            end
         end
      end

      op.words_left = count_in_use_ff ? remaining_after[twa_pkg::CountWidth-1:0] : '0;
   end

   assign push    = accept && (op.store_valid || op.done_valid);
   assign push_op = op;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff            <= 1'b0;
         word_accum_ff      <= '0;
         char_position_ff   <= '0;
         at_first_char_ff   <= 1'b1;
         prev_was_mark_ff   <= 1'b0;
         core_address_ff    <= '0;
         words_remaining_ff <= '0;
         count_in_use_ff    <= 1'b0;
      end else begin
         busy_ff            <= busy_in;
         word_accum_ff      <= word_accum_in;
         char_position_ff   <= char_position_in;
         at_first_char_ff   <= at_first_char_in;
         prev_was_mark_ff   <= prev_was_mark_in;
         core_address_ff    <= core_address_in;
         words_remaining_ff <= words_remaining_in;
         count_in_use_ff    <= count_in_use_in;
      end
   end

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      accept && !busy_ff && req_func != twa_pkg::FUNC_START |-> !push)
      else $error("result pushed while no read is open");

   a_budget_bound: assert property (@(posedge clock) disable iff (reset)
      words_remaining_ff <= twa_pkg::DefaultWords)
      else $error("word budget above its limit");

endmodule

// ===== rtl/twa_queue.sv =====
// Short operation queue between the front and back ends.
`timescale 1ns / 1ps

module twa_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  twa_pkg::op_type push_op,
   input  logic            pop,
   output logic            full,
   output logic            head_valid,
   output twa_pkg::op_type head_op
);

   twa_pkg::op_type                entries_ff [twa_pkg::QueueDepth];
   logic [twa_pkg::QueueAw-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [twa_pkg::QueueAw:0]      count_ff, count_in;

   assign full       = count_ff == (twa_pkg::QueueAw+1)'(twa_pkg::QueueDepth);
   assign head_valid = count_ff != '0;
   assign head_op    = entries_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from an empty queue");

endmodule

// ===== rtl/twa_back.sv =====
// Back end: expands queued operations into result beats behind an output register.
`timescale 1ns / 1ps

module twa_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                head_valid,
   input  twa_pkg::op_type                     head_op,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_kind,
   output logic [twa_pkg::AddrWidth-1:0]       rsp_mem_address,
   output logic [twa_pkg::WordWidth-1:0]       rsp_mem_word,
   output logic [twa_pkg::StatusWidth-1:0]     rsp_status,
   output logic [twa_pkg::CountWidth-1:0]      rsp_words_left,
   output logic [twa_pkg::PosWidth-1:0]        rsp_chars_in_word,
   output logic                                rsp_last
);

   logic                               rsp_valid_ff;
   logic                               rsp_kind_ff;
   logic [twa_pkg::AddrWidth-1:0]      rsp_mem_address_ff;
   logic [twa_pkg::WordWidth-1:0]      rsp_mem_word_ff;
   logic [twa_pkg::StatusWidth-1:0]    rsp_status_ff;
   logic [twa_pkg::CountWidth-1:0]     rsp_words_left_ff;
   logic [twa_pkg::PosWidth-1:0]       rsp_chars_in_word_ff;
   logic                               rsp_last_ff;
   logic                               store_sent_ff;

   logic                               load;
   logic                               store_phase;

   assign load        = !rsp_valid_ff || rsp_ready;
   assign store_phase = head_op.store_valid && !store_sent_ff;
   // hold the entry while its done beat is still to follow the store
   assign pop         = load && head_valid && !(store_phase && head_op.done_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         store_sent_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= head_valid;
         if (head_valid) begin
            store_sent_ff <= store_phase && head_op.done_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load && head_valid) begin
         if (store_phase) begin
            rsp_kind_ff          <= twa_pkg::KIND_STORE;
            rsp_mem_address_ff   <= head_op.store_address;
            rsp_mem_word_ff      <= head_op.store_word;
            rsp_status_ff        <= '0;
            rsp_words_left_ff    <= '0;
            rsp_chars_in_word_ff <= '0;
            rsp_last_ff          <= !head_op.done_valid;
         end else begin
            rsp_kind_ff          <= twa_pkg::KIND_DONE;
            rsp_mem_address_ff   <= head_op.done_address;
            rsp_mem_word_ff      <= '0;
            rsp_status_ff        <= head_op.status;
            rsp_words_left_ff    <= head_op.words_left;
            rsp_chars_in_word_ff <= head_op.chars_in_word;
            rsp_last_ff          <= 1'b1;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_mem_address   = rsp_mem_address_ff;
   assign rsp_mem_word      = rsp_mem_word_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_words_left    = rsp_words_left_ff;
   assign rsp_chars_in_word = rsp_chars_in_word_ff;
   assign rsp_last          = rsp_last_ff;

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == twa_pkg::KIND_DONE |-> rsp_last_ff)
      else $error("done beat without last");

   a_split_entry_held: assert property (@(posedge clock) disable iff (reset)
      store_sent_ff |-> head_valid && head_op.done_valid)
      else $error("pending done beat lost its queue entry");

endmodule
